### hdl/dtct_pkg.sv
// Shared constants and types for the delayed task countdown table.
`timescale 1ns / 1ps

package dtct_pkg;

   // Table geometry
   localparam int SLOTS  = 10;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   // Field widths
   localparam int ID_W         = 8;
   localparam int DELAY_W      = 16;
   localparam int SLOT_FIELD_W = 6;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 16;

   // Request operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Response kinds
   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_FIRE = 1'b1;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ADD   = 4'b0010,
      ST_TICK  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

endpackage

### hdl/dtct_ram.sv
// Simple dual-port synchronous RAM with registered, enable-held read data.
`timescale 1ns / 1ps

module dtct_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 10
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, output holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/delayed_task_countdown_table_unit.sv
// Top level of the delayed task countdown table: sequencer, slot memories, response register.
`timescale 1ns / 1ps

// Delayed task countdown table.
// Request channel (req_*): tuser = op (add or tick), tdata = task id and delay.
// An add claims the lowest slot whose countdown is zero, loads id and delay,
// and answers with one acknowledge (accepted, slot). A tick decrements every
// running countdown and returns one fired transaction per slot reaching zero,
// in slot order, tlast on the final one; a quiet tick returns nothing.
// Response channel (rsp_*): tuser = kind, tlast = last result of the request.
// Countdowns and task ids live in two RAMs with registered read data that
// are walked one slot per cycle while no result is stalled; a slot is read,
// modified and written back once its data returns while the next slot is read.
// One request is in work at a time; req_tready is high only while the
// sequencer is idle. A stalled response register freezes the walk (RAM
// reads held) when a result must be pushed into it, until the transaction
// is taken; a finished result may wait while the next request is accepted.
// After reset a clearing pass writes zero to every countdown, one slot per
// cycle; req_tready stays low until it ends.

module delayed_task_countdown_table_unit (
   input  logic                             clock,
   input  logic                             reset,
   // request
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [dtct_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] task_id, [23:8] delay
   input  logic                             req_tuser,  // [0] op
   // response
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [dtct_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // [0] accepted, [6:1] slot,
                                                        // [14:7] fired_id, [15] zero
   output logic                             rsp_tuser,  // [0] kind
   output logic                             rsp_tlast
);

   localparam int SW = dtct_pkg::SLOT_W;
   localparam int CW = dtct_pkg::CNT_W;
   localparam int DW = dtct_pkg::DELAY_W;
   localparam int IW = dtct_pkg::ID_W;

   dtct_pkg::state_type state_ff, state_in;

   // request hold
   logic          op_ff;
   logic [IW-1:0] id_ff;
   logic [DW-1:0] delay_ff;

   // walk pipeline
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic          s1_valid_ff, s1_valid_in;
   logic [SW-1:0] s1_idx_ff, s1_idx_in;

   // clear sweep after reset
   logic          clr_busy_ff, clr_busy_in;
   logic [CW-1:0] clr_idx_ff, clr_idx_in;

   // pending fired result (held until we know whether it is the last)
   logic          pend_valid_ff, pend_valid_in;
   logic [SW-1:0] pend_slot_ff, pend_slot_in;
   logic [IW-1:0] pend_id_ff, pend_id_in;

   // response register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_kind_ff, rsp_acc_ff, rsp_last_ff;
   logic [dtct_pkg::SLOT_FIELD_W-1:0] rsp_slot_ff;
   logic [IW-1:0]                     rsp_id_ff;

   // push into the response register
   logic                              push;
   logic                              push_kind, push_acc, push_last;
   logic [dtct_pkg::SLOT_FIELD_W-1:0] push_slot;
   logic [IW-1:0]                     push_id;

   // memory ports
   logic          rd_en;
   logic          cd_wr_en, task_wr_en;
   logic [SW-1:0] wr_addr;
   logic [DW-1:0] cd_wr_data;
   logic [DW-1:0] cd_rd;
   logic [IW-1:0] task_rd;

   logic req_accept, out_free, issue_ok, s1_last, fire;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign issue_ok   = rd_idx_ff < CW'(dtct_pkg::SLOTS);
   assign s1_last    = s1_idx_ff == SW'(dtct_pkg::SLOTS - 1);
   assign fire       = s1_valid_ff && (cd_rd == DW'(1));
   assign req_tready = (state_ff == dtct_pkg::ST_IDLE) && !clr_busy_ff;

   // Countdown and task id memories
   dtct_ram #(.WIDTH(DW), .DEPTH(dtct_pkg::SLOTS)) u_cd_ram (
      .clock   (clock),
      .wr_en   (cd_wr_en),
      .wr_addr (wr_addr),
      .wr_data (cd_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[SW-1:0]),
      .rd_data (cd_rd)
   );

   dtct_ram #(.WIDTH(IW), .DEPTH(dtct_pkg::SLOTS)) u_task_ram (
      .clock   (clock),
      .wr_en   (task_wr_en),
      .wr_addr (wr_addr),
      .wr_data (id_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[SW-1:0]),
      .rd_data (task_rd)
   );

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      rd_idx_in     = rd_idx_ff;
      s1_valid_in   = s1_valid_ff;
      s1_idx_in     = s1_idx_ff;
      clr_busy_in   = clr_busy_ff;
      clr_idx_in    = clr_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_id_in    = pend_id_ff;
      rd_en         = 1'b0;
      cd_wr_en      = 1'b0;
      task_wr_en    = 1'b0;
      wr_addr       = s1_idx_ff;
      cd_wr_data    = cd_rd - DW'(1);
      push          = 1'b0;
      push_kind     = dtct_pkg::KIND_ACK;
      push_acc      = 1'b0;
      push_slot     = '0;
      push_id       = '0;
      push_last     = 1'b1;

      unique case (state_ff)
         dtct_pkg::ST_IDLE: begin
            if (clr_busy_ff) begin
               // clear sweep: mark every slot free
               cd_wr_en   = 1'b1;
               wr_addr    = clr_idx_ff[SW-1:0];
               cd_wr_data = '0;
               clr_idx_in = clr_idx_ff + CW'(1);
               if (clr_idx_ff[SW-1:0] == SW'(dtct_pkg::SLOTS - 1)) begin
                  clr_busy_in = 1'b0;
               end
            end else if (req_accept) begin
               state_in    = (req_tuser == dtct_pkg::OP_ADD) ? dtct_pkg::ST_ADD
                                                             : dtct_pkg::ST_TICK;
               rd_idx_in   = '0;
               s1_valid_in = 1'b0;
            end
         end

         dtct_pkg::ST_ADD: begin
            if (s1_valid_ff && ((cd_rd == '0) || s1_last)) begin
               // free slot found, or table full
               if (out_free) begin
                  push      = 1'b1;
                  push_acc  = (cd_rd == '0);
                  push_slot = (cd_rd == '0) ? dtct_pkg::SLOT_FIELD_W'(s1_idx_ff) : '0;
                  if (cd_rd == '0) begin
                     cd_wr_en   = 1'b1;
                     task_wr_en = 1'b1;
                     cd_wr_data = delay_ff;
                  end
                  s1_valid_in = 1'b0;
                  state_in    = dtct_pkg::ST_IDLE;
               end
            end else begin
               rd_en       = issue_ok;
               s1_valid_in = issue_ok;
               s1_idx_in   = rd_idx_ff[SW-1:0];
               rd_idx_in   = rd_idx_ff + CW'(issue_ok);
            end
         end

         dtct_pkg::ST_TICK: begin
            if (!(fire && pend_valid_ff && !out_free)) begin
               if (s1_valid_ff && (cd_rd != '0)) begin
                  cd_wr_en = 1'b1;
               end
               if (fire) begin
                  if (pend_valid_ff) begin
                     push      = 1'b1;
                     push_kind = dtct_pkg::KIND_FIRE;
                     push_slot = dtct_pkg::SLOT_FIELD_W'(pend_slot_ff);
                     push_id   = pend_id_ff;
                     push_last = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = s1_idx_ff;
                  pend_id_in    = task_rd;
               end
               if (s1_valid_ff && s1_last) begin
                  s1_valid_in = 1'b0;
                  state_in    = dtct_pkg::ST_FLUSH;
               end else begin
                  rd_en       = issue_ok;
                  s1_valid_in = issue_ok;
                  s1_idx_in   = rd_idx_ff[SW-1:0];
                  rd_idx_in   = rd_idx_ff + CW'(issue_ok);
               end
            end
         end

         dtct_pkg::ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = dtct_pkg::ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_kind     = dtct_pkg::KIND_FIRE;
               push_slot     = dtct_pkg::SLOT_FIELD_W'(pend_slot_ff);
               push_id       = pend_id_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = dtct_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = dtct_pkg::ST_IDLE;
         end
      endcase
   end

   // Response register control
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtct_pkg::ST_IDLE;
         s1_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         clr_busy_ff   <= 1'b1;
         clr_idx_ff    <= '0;
         rd_idx_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         s1_valid_ff   <= s1_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         clr_busy_ff   <= clr_busy_in;
         clr_idx_ff    <= clr_idx_in;
         rd_idx_ff     <= rd_idx_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_idx_ff    <= s1_idx_in;
      pend_slot_ff <= pend_slot_in;
      pend_id_ff   <= pend_id_in;
      if (req_accept) begin
         op_ff    <= req_tuser;
         id_ff    <= req_tdata[IW-1:0];
         delay_ff <= req_tdata[IW+DW-1:IW];
      end
      if (push) begin
         rsp_kind_ff <= push_kind;
         rsp_acc_ff  <= push_acc;
         rsp_slot_ff <= push_slot;
         rsp_id_ff   <= push_id;
         rsp_last_ff <= push_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_id_ff, rsp_slot_ff, rsp_acc_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef ASSERT_OFF
   // a push never overwrites a transaction that is still waiting
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("response register overwritten");

   // the pending fire exists only during a tick walk or its flush
   a_pend_state: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == dtct_pkg::ST_TICK || state_ff == dtct_pkg::ST_FLUSH))
      else $error("pending fire outside tick");

   // walk writes only target a slot whose data is in hand
   a_wr_valid: assert property (@(posedge clock) disable iff (reset)
      (task_wr_en || (cd_wr_en && !clr_busy_ff)) |-> s1_valid_ff)
      else $error("memory write without slot data");

   // an accepted add reports a slot inside the table
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_acc_ff) |-> (rsp_slot_ff < dtct_pkg::SLOT_FIELD_W'(dtct_pkg::SLOTS)))
      else $error("acknowledged slot out of range");

   // the held op matches the walk being run
   a_op_state: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dtct_pkg::ST_ADD) |-> (op_ff == dtct_pkg::OP_ADD))
      else $error("add walk with tick request");
`endif

endmodule

### dv/testbench.sv
// Self-checking testbench for the delayed task countdown table unit.
`timescale 1ns / 1ps

module testbench;

   // One request: add a task or advance all countdowns by one tick
   typedef struct packed {
      logic                         op;
      logic [dtct_pkg::ID_W-1:0]    task_id;
      logic [dtct_pkg::DELAY_W-1:0] delay;
   } table_op_type;

   // One response: add acknowledge or fired task
   typedef struct packed {
      logic                              kind;
      logic                              accepted;
      logic [dtct_pkg::SLOT_FIELD_W-1:0] slot;
      logic [dtct_pkg::ID_W-1:0]         fired_id;
      logic                              last;
   } slot_event_type;

   localparam int RANDOM_OPS    = 228;
   localparam int DRAIN_CYCLES  = 40;
   localparam int MAX_MSG_LINES = 40;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [dtct_pkg::REQ_DATA_W-1:0] req_tdata  = '0;  // [7:0] task_id, [23:8] delay
   logic                            req_tuser  = 1'b0;  // [0] op
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [dtct_pkg::RSP_DATA_W-1:0] rsp_tdata;  // [0] accepted, [6:1] slot, [14:7] fired_id,
                                                // [15] zero
   logic                            rsp_tuser;  // [0] kind
   logic                            rsp_tlast;

   table_op_type   op_queue[$];
   slot_event_type slot_events[$];
   logic [dtct_pkg::DELAY_W-1:0] shadow_countdown[dtct_pkg::SLOTS];
   logic [dtct_pkg::ID_W-1:0]    shadow_task[dtct_pkg::SLOTS];
   int total_ops    = 0;
   int ops_accepted = 0;
   int error_count  = 0;

   delayed_task_countdown_table_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // Idle rates per third of the run: sender light / receiver heavy, swapped, none
   function automatic int sender_idle_pct();
      int third;
      third = (total_ops == 0) ? 0 : (ops_accepted * 3) / total_ops;
      return (third == 0) ? 7 : (third == 1) ? 56 : 0;
   endfunction

   function automatic int receiver_idle_pct();
      int third;
      third = (total_ops == 0) ? 0 : (ops_accepted * 3) / total_ops;
      return (third == 0) ? 56 : (third == 1) ? 7 : 0;
   endfunction

   // Shadow table update; queues the responses this request must produce
   function automatic void apply_to_table(input logic op,
                                          input logic [dtct_pkg::REQ_DATA_W-1:0] data);
      logic [dtct_pkg::ID_W-1:0]    tid;
      logic [dtct_pkg::DELAY_W-1:0] dly;
      int                           first_free;
      slot_event_type               ev;
      slot_event_type               held;
      bit                           have_held;
      tid        = data[dtct_pkg::ID_W-1:0];
      dly        = data[dtct_pkg::ID_W +: dtct_pkg::DELAY_W];
      first_free = -1;
      have_held  = 1'b0;
      held       = '0;
      if (op == dtct_pkg::OP_ADD) begin
         for (int s = 0; s < dtct_pkg::SLOTS; s++) begin
            if (first_free < 0 && shadow_countdown[s] == '0) first_free = s;
         end
         ev = '0;
         ev.kind = dtct_pkg::KIND_ACK;
         ev.last = 1'b1;
         if (first_free >= 0) begin
            shadow_task[first_free]      = tid;
            shadow_countdown[first_free] = dly;
            ev.accepted = 1'b1;
            ev.slot     = first_free[dtct_pkg::SLOT_FIELD_W-1:0];
         end
         slot_events.push_back(ev);
      end else begin
         // every running countdown drops by one; zero crossings fire in slot order
         for (int s = 0; s < dtct_pkg::SLOTS; s++) begin
            if (shadow_countdown[s] != '0) begin
               shadow_countdown[s] = shadow_countdown[s] - 1'b1;
               if (shadow_countdown[s] == '0) begin
                  if (have_held) slot_events.push_back(held);
                  held          = '0;
                  held.kind     = dtct_pkg::KIND_FIRE;
                  held.slot     = s[dtct_pkg::SLOT_FIELD_W-1:0];
                  held.fired_id = shadow_task[s];
                  have_held     = 1'b1;
               end
            end
         end
         if (have_held) begin
            held.last = 1'b1;
            slot_events.push_back(held);
         end
      end
   endfunction

   // Message output is capped so a cascade stays readable; the count is exact
   task automatic report_mismatch(input string what, input int want, input int got);
      if (error_count < MAX_MSG_LINES)
         $display("%0t ns: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
      error_count++;
   endtask

   task automatic check_result(input logic kind, input logic [dtct_pkg::RSP_DATA_W-1:0] data,
                               input logic last);
      slot_event_type want;
      if (slot_events.size() == 0) begin
         report_mismatch("unexpected response, count", 0, 1);
      end else begin
         want = slot_events.pop_front();
         if (kind !== want.kind) report_mismatch("kind", want.kind, kind);
         if (data[0] !== want.accepted) report_mismatch("accepted", want.accepted, data[0]);
         if (data[6:1] !== want.slot) report_mismatch("slot", want.slot, data[6:1]);
         if (data[14:7] !== want.fired_id) report_mismatch("fired_id", want.fired_id, data[14:7]);
         if (last !== want.last) report_mismatch("last", want.last, last);
      end
   endtask

   task automatic push_op(input logic op, input int tid, input int dly);
      table_op_type item;
      item.op      = op;
      item.task_id = tid[dtct_pkg::ID_W-1:0];
      item.delay   = dly[dtct_pkg::DELAY_W-1:0];
      op_queue.push_back(item);
   endtask

   // Request driver: hold an offered transaction until it is taken
   always @(posedge clock) begin : drive_requests
      table_op_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_to_table(req_tuser, req_tdata);
            ops_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (op_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
               item = op_queue.pop_front();
               req_tuser  <= item.op;
               req_tdata  <= {item.delay, item.task_id};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random backpressure
   always @(posedge clock) begin : watch_responses
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result(rsp_tuser, rsp_tdata, rsp_tlast);
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   // Stimulus, reset and end of run
   initial begin
      int pick;
      int burst;
      int dly;
      for (int s = 0; s < dtct_pkg::SLOTS; s++) begin
         shadow_countdown[s] = '0;
         shadow_task[s]      = '0;
      end

      // quiet tick on an empty table, then a zero-delay add that leaves slot 0 free
      push_op(dtct_pkg::OP_TICK, 0, 0);
      push_op(dtct_pkg::OP_ADD, 8'h00, 0);
      // fill every slot with delay 1, then an add into the full table
      push_op(dtct_pkg::OP_ADD, 8'hFF, 1);
      for (int s = 1; s < dtct_pkg::SLOTS; s++) push_op(dtct_pkg::OP_ADD, 8'h10 + s, 1);
      push_op(dtct_pkg::OP_ADD, 8'hA5, 16'hFFFF);
      // all slots fire on one tick; the next tick is quiet
      push_op(dtct_pkg::OP_TICK, 0, 0);
      push_op(dtct_pkg::OP_TICK, 0, 0);
      // staggered delays and a zero-delay add in the middle of the search
      push_op(dtct_pkg::OP_ADD, 8'h3C, 3);
      push_op(dtct_pkg::OP_ADD, 8'h77, 2);
      push_op(dtct_pkg::OP_ADD, 8'h5A, 0);
      push_op(dtct_pkg::OP_ADD, 8'hC3, 2);
      push_op(dtct_pkg::OP_TICK, 0, 0);
      push_op(dtct_pkg::OP_TICK, 0, 0);
      push_op(dtct_pkg::OP_TICK, 0, 0);

      // random bursts of adds (mostly short delays) and runs of ticks
      burst = 0;
      while (burst < RANDOM_OPS) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            // an occasional long burst overruns the table
            for (int k = (pick < 8) ? $urandom_range(12, 8) : $urandom_range(5, 1);
                 k > 0; k--) begin
               pick = $urandom_range(99);
               if (pick < 2) dly = $urandom_range(16'hFFFF);
               else if (pick < 10) dly = 0;
               else if (pick < 20) dly = $urandom_range(40, 16);
               else dly = $urandom_range(15, 1);
               push_op(dtct_pkg::OP_ADD, $urandom_range(255), dly);
               burst++;
            end
         end else begin
            for (int k = $urandom_range(8, 1); k > 0; k--) begin
               push_op(dtct_pkg::OP_TICK, $urandom_range(255), $urandom_range(16'hFFFF));
               burst++;
            end
         end
      end
      total_ops = op_queue.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (ops_accepted < total_ops) @(posedge clock);
      while (slot_events.size() > 0) @(posedge clock);
      // a trailing quiet tick may still be in work; catch any stray response
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run, including any clear after reset
   initial begin
      #2_000_000;
      $display("testbench failed");
      $finish;
   end

endmodule
